FILE: sv/jpeg_marker_validator_assert.svh
// Assertion macros used by the checker file of the marker validator.
`ifndef JPEG_MARKER_VALIDATOR_ASSERT_SVH
`define JPEG_MARKER_VALIDATOR_ASSERT_SVH

// Clocked assertion, ignored while reset is asserted.
`define JMV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jmv check failed");

// Clocked assertion that also holds across reset.
`define JMV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("jmv check failed");

`endif

FILE: sv/jmv_pkg.sv
// ----------------------------------------------------------------------------
// jmv_pkg
// Shared types and constants of the JPEG marker validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jmv_pkg;

    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;
    localparam logic [POS_W-1:0] MAX_IMAGE_BYTES = 17'd65536;
    localparam logic [POS_W-1:0] MIN_IMAGE_BYTES = 17'd4;

    localparam logic [15:0] WIDTH_RESET  = 16'd160;
    localparam logic [15:0] HEIGHT_RESET = 16'd160;

    // register map, decoded on paddr[2]
    localparam logic REG_EXPECTED_WIDTH  = 1'b0;
    localparam logic REG_EXPECTED_HEIGHT = 1'b1;

    // marker codes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_SOF15  = 8'hCF;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_JPG    = 8'hC8;
    localparam logic [7:0] MK_DAC    = 8'hCC;
    localparam logic [7:0] SOF_PRECISION = 8'd8;

    typedef enum logic [3:0] {
        PH_SCAN,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_SOF_LEN_HI,
        PH_SOF_LEN_LO,
        PH_SOF_BODY
    } phase_t;

    typedef struct packed {
        logic push;
        logic image_valid;
    } verdict_t;

endpackage

FILE: sv/jmv_parser.sv
// ----------------------------------------------------------------------------
// jmv_parser
// Per-byte marker walk; updates image state on each accepted item and
// issues the verdict on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jmv_parser #(
    parameter logic [jmv_pkg::POS_W-1:0] MAX_IMAGE_BYTES = jmv_pkg::MAX_IMAGE_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_accept,
    input  logic [7:0]                    data_byte,
    input  logic [jmv_pkg::POS_W-1:0]     image_length,
    input  logic                          is_last,
    input  logic [15:0]                   expected_width,
    input  logic [15:0]                   expected_height,
    output jmv_pkg::verdict_t             verdict
);

    logic [jmv_pkg::POS_W-1:0] position_reg, position_next;
    jmv_pkg::phase_t           phase_reg, phase_next;
    logic [15:0]               seg_len_reg, seg_len_next;
    logic [15:0]               skip_reg, skip_next;
    logic [2:0]                hdr_idx_reg, hdr_idx_next;
    logic [15:0]               cap_height_reg, cap_height_next;
    logic [15:0]               cap_width_reg, cap_width_next;
    logic                      dims_match_reg, dims_match_next;
    logic                      failed_reg, failed_next;
    logic                      stopped_reg, stopped_next;
    logic [7:0]                prev_byte_reg, prev_byte_next;

    logic [jmv_pkg::POS_W:0] pos_ext, len_ext;
    logic [15:0]             seg;
    logic [15:0]             skip_dec;
    logic                    is_sof;
    logic                    ok;

    assign pos_ext = {1'b0, position_reg};
    assign len_ext = {1'b0, image_length};
    assign seg     = {seg_len_reg[7:0], data_byte};
    assign is_sof  = (phase_reg == jmv_pkg::PH_SOF_LEN_LO);
    assign skip_dec = (skip_reg != 16'd0) ? skip_reg - 16'd1 : 16'd0;

    always_comb begin
        phase_next      = phase_reg;
        seg_len_next    = seg_len_reg;
        skip_next       = skip_reg;
        hdr_idx_next    = hdr_idx_reg;
        cap_height_next = cap_height_reg;
        cap_width_next  = cap_width_reg;
        dims_match_next = dims_match_reg;
        failed_next     = failed_reg;
        stopped_next    = stopped_reg;
        prev_byte_next  = data_byte;
        position_next   = (position_reg == jmv_pkg::POS_MAX) ? position_reg
                                                             : position_reg + 1'b1;

        if (position_reg == '0) begin
            if (data_byte != jmv_pkg::MK_PREFIX) failed_next = 1'b1;
        end else if (position_reg == {{(jmv_pkg::POS_W-1){1'b0}}, 1'b1}) begin
            if (data_byte != jmv_pkg::MK_SOI) failed_next = 1'b1;
        end else if (!failed_reg && !stopped_reg) begin
            case (phase_reg)
                jmv_pkg::PH_SCAN: begin
                    // no room left for a marker plus length
                    if (pos_ext + 18'd3 >= len_ext) begin
                        stopped_next = 1'b1;
                    end else if (data_byte == jmv_pkg::MK_PREFIX) begin
                        phase_next = jmv_pkg::PH_MARKER;
                    end
                end
                jmv_pkg::PH_MARKER: begin
                    // FF after FF is fill
                    if (data_byte != jmv_pkg::MK_PREFIX) begin
                        if (data_byte == jmv_pkg::MK_EOI || data_byte == jmv_pkg::MK_SOS) begin
                            stopped_next = 1'b1;
                        end else if (data_byte inside {[jmv_pkg::MK_RST0:jmv_pkg::MK_RST7]}
                                     || data_byte == jmv_pkg::MK_TEM) begin
                            phase_next = jmv_pkg::PH_SCAN;
                        end else if (pos_ext + 18'd3 > len_ext) begin
                            failed_next = 1'b1;
                        end else if (data_byte == jmv_pkg::MK_SOF0) begin
                            phase_next = jmv_pkg::PH_SOF_LEN_HI;
                        end else if (data_byte inside {[jmv_pkg::MK_SOF1:jmv_pkg::MK_SOF15]}
                                     && !(data_byte inside {jmv_pkg::MK_DHT, jmv_pkg::MK_JPG,
                                                            jmv_pkg::MK_DAC})) begin
                            failed_next = 1'b1;
                        end else begin
                            phase_next = jmv_pkg::PH_LEN_HI;
                        end
                    end
                end
                jmv_pkg::PH_LEN_HI: begin
                    seg_len_next = {8'd0, data_byte};
                    phase_next   = jmv_pkg::PH_LEN_LO;
                end
                jmv_pkg::PH_SOF_LEN_HI: begin
                    seg_len_next = {8'd0, data_byte};
                    phase_next   = jmv_pkg::PH_SOF_LEN_LO;
                end
                jmv_pkg::PH_LEN_LO, jmv_pkg::PH_SOF_LEN_LO: begin
                    seg_len_next = seg;
                    // position is at least 3 here
                    if (seg < 16'd2 || (pos_ext - 18'd1 + {2'b00, seg}) > len_ext
                        || (is_sof && seg < 16'd8)) begin
                        failed_next = 1'b1;
                    end else begin
                        skip_next    = seg - 16'd2;
                        hdr_idx_next = 3'd0;
                        if (seg == 16'd2) begin
                            phase_next = jmv_pkg::PH_SCAN;
                        end else begin
                            phase_next = is_sof ? jmv_pkg::PH_SOF_BODY : jmv_pkg::PH_SKIP;
                        end
                    end
                end
                jmv_pkg::PH_SKIP, jmv_pkg::PH_SOF_BODY: begin
                    if (phase_reg == jmv_pkg::PH_SOF_BODY) begin
                        case (hdr_idx_reg)
                            3'd0: if (data_byte != jmv_pkg::SOF_PRECISION) failed_next = 1'b1;
                            3'd1: cap_height_next = {data_byte, 8'd0};
                            3'd2: cap_height_next = {cap_height_reg[15:8], data_byte};
                            3'd3: cap_width_next  = {data_byte, 8'd0};
                            3'd4: begin
                                cap_width_next  = {cap_width_reg[15:8], data_byte};
                                dims_match_next = (cap_height_reg == expected_height) &&
                                    ({cap_width_reg[15:8], data_byte} == expected_width);
                            end
                            default: ;
                        endcase
                        if (hdr_idx_reg < 3'd5) hdr_idx_next = hdr_idx_reg + 3'd1;
                    end
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) phase_next = jmv_pkg::PH_SCAN;
                end
                default: phase_next = jmv_pkg::PH_SCAN;
            endcase
        end

        ok = (pos_ext + 18'd1 == len_ext)
             && image_length >= jmv_pkg::MIN_IMAGE_BYTES
             && image_length <= MAX_IMAGE_BYTES
             && prev_byte_reg == jmv_pkg::MK_PREFIX
             && data_byte == jmv_pkg::MK_EOI
             && !failed_next && dims_match_next;

        verdict.push        = item_accept && is_last;
        verdict.image_valid = ok;

        // verdict closes the image
        if (is_last) begin
            position_next   = '0;
            phase_next      = jmv_pkg::PH_SCAN;
            seg_len_next    = 16'd0;
            skip_next       = 16'd0;
            hdr_idx_next    = 3'd0;
            cap_height_next = 16'd0;
            cap_width_next  = 16'd0;
            dims_match_next = 1'b0;
            failed_next     = 1'b0;
            stopped_next    = 1'b0;
            prev_byte_next  = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            phase_reg      <= jmv_pkg::PH_SCAN;
            seg_len_reg    <= 16'd0;
            skip_reg       <= 16'd0;
            hdr_idx_reg    <= 3'd0;
            cap_height_reg <= 16'd0;
            cap_width_reg  <= 16'd0;
            dims_match_reg <= 1'b0;
            failed_reg     <= 1'b0;
            stopped_reg    <= 1'b0;
            prev_byte_reg  <= 8'd0;
        end else if (item_accept) begin
            position_reg   <= position_next;
            phase_reg      <= phase_next;
            seg_len_reg    <= seg_len_next;
            skip_reg       <= skip_next;
            hdr_idx_reg    <= hdr_idx_next;
            cap_height_reg <= cap_height_next;
            cap_width_reg  <= cap_width_next;
            dims_match_reg <= dims_match_next;
            failed_reg     <= failed_next;
            stopped_reg    <= stopped_next;
            prev_byte_reg  <= prev_byte_next;
        end
    end

endmodule

FILE: sv/jmv_result_buf.sv
// ----------------------------------------------------------------------------
// jmv_result_buf
// Two-entry result buffer; output register plus one skid entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jmv_result_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  jmv_pkg::verdict_t verdict,
    output logic              space_avail,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              image_valid
);

    logic [1:0] count_reg, count_next;
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic       pop;

    assign pop         = m_tvalid && m_tready;
    assign m_tvalid    = (count_reg != 2'd0);
    assign space_avail = (count_reg != 2'd2);
    assign image_valid = head_reg;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (verdict.push && !pop) begin
            count_next = count_reg + 2'd1;
            if (count_reg == 2'd0) head_next = verdict.image_valid;
            else                   tail_next = verdict.image_valid;
        end else if (pop && !verdict.push) begin
            count_next = count_reg - 2'd1;
            head_next  = tail_reg;
        end else if (pop && verdict.push) begin
            // push is blocked when full, so one item is held here
            head_next = verdict.image_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

FILE: sv/jpeg_marker_validator.sv
// ----------------------------------------------------------------------------
// jpeg_marker_validator
// Byte-serial structural check of a baseline JPEG image.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one image byte per item: s_tdata holds the byte
//   and the total image length, s_tlast flags the final byte. Every byte is
//   checked in the cycle it is accepted; one byte per cycle is sustained while
//   s_tready is high. On the item with s_tlast set, a single verdict item
//   (m_tdata[0]) is issued on the output stream; no other byte produces output.
//   The image state is cleared after the verdict. Expected frame width and
//   height are set over the APB port (offset 0x0 and 0x4, reset 160) and
//   are to be written by the user only while no image is in flight; the block
//   does not enforce this. A stalled output receiver is absorbed by a two-entry
//   result buffer; s_tready drops only when two verdicts are waiting, so a
//   stall holds the input only while both buffer entries are occupied. Reset
//   (aresetn low, synchronous) clears the parse state and the buffer and
//   returns the size registers to 160; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_marker_validator #(
    parameter logic [jmv_pkg::POS_W-1:0] MAX_IMAGE_BYTES = jmv_pkg::MAX_IMAGE_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // data_byte [7:0], image_length [24:8], zero [31:25]
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tlast,
    // image_valid [0], zero [7:1]
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]       exp_width_reg;
    logic [15:0]       exp_height_reg;
    logic              cfg_write;
    logic              item_accept;
    logic              image_valid;
    jmv_pkg::verdict_t verdict;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_width_reg  <= jmv_pkg::WIDTH_RESET;
            exp_height_reg <= jmv_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == jmv_pkg::REG_EXPECTED_WIDTH) exp_width_reg  <= pwdata[15:0];
            else                                         exp_height_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        if (paddr[2] == jmv_pkg::REG_EXPECTED_HEIGHT) prdata = {16'd0, exp_height_reg};
        else                                          prdata = {16'd0, exp_width_reg};
    end

    assign item_accept = s_tvalid && s_tready;

    jmv_parser #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_accept     (item_accept),
        .data_byte       (s_tdata[7:0]),
        .image_length    (s_tdata[24:8]),
        .is_last         (s_tlast),
        .expected_width  (exp_width_reg),
        .expected_height (exp_height_reg),
        .verdict         (verdict)
    );

    jmv_result_buf u_result_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .verdict     (verdict),
        .space_avail (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .image_valid (image_valid)
    );

    assign m_tdata = {7'd0, image_valid};

endmodule

FILE: sv/jmv_checker.sv
// ----------------------------------------------------------------------------
// jmv_checker
// Port-level checks of the marker validator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jpeg_marker_validator_assert.svh"

module jmv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic [7:0]  m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    `JMV_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `JMV_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[7:1] == 7'd0)
    `JMV_ASSERT(a_last_gives_item, aclk, aresetn, s_tvalid && s_tready && s_tlast && !m_tvalid |=> m_tvalid)
    `JMV_ASSERT(a_stall_only_if_pending, aclk, aresetn, !s_tready |-> m_tvalid)
    `JMV_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind jpeg_marker_validator jmv_checker u_jmv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
